### src/usx_pkg.sv
// ----------------------------------------------------------------------------
// usx_pkg
// Shared types and constants of the ungapped seed extension core.
// ----------------------------------------------------------------------------
package usx_pkg;

   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_SEED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FWD    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BWD    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd3;

   localparam int SYM_W = 8;
   localparam logic [SYM_W-1:0] SEP_SYMBOL     = 8'h2A;
   localparam logic [SYM_W-1:0] UNKNOWN_SYMBOL = 8'h4E;

   localparam int WLEN_W  = 6;
   localparam int MINL_W  = 32;
   localparam int PCT_W   = 7;
   localparam int SCORE_W = 31;
   localparam int RUN_W   = SCORE_W + 1;
   localparam int SUM_W   = SCORE_W + 2;
   localparam int NUM_W   = SCORE_W + PCT_W;

   localparam logic [SCORE_W-1:0] SCORE_MAX  = '1;
   localparam logic [RUN_W-1:0]   PAIR_POINT = 32'd4;
   localparam logic [RUN_W-1:0]   UNK_POINT  = 32'd1;
   localparam logic [NUM_W-1:0]   SCALE      = 38'd100;
   localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;

   localparam int DEN_SHIFT = 2;
   localparam int QUO_W     = 8;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIM_THRESH  = 2'd2;

   localparam logic [WLEN_W-1:0] WLEN_RESET   = 6'd12;
   localparam logic [MINL_W-1:0] MINL_RESET   = 32'd40;
   localparam logic [PCT_W-1:0]  THRESH_RESET = 7'd60;

   typedef struct packed {
      logic step;
      logic calc;
      logic div_step;
      logic load;
   } usx_cmd_type;

endpackage

### src/usx_if.sv
// ----------------------------------------------------------------------------
// usx_if
// Channel interfaces of the ungapped seed extension core.
// ----------------------------------------------------------------------------
interface usx_req_if #(parameter int COORD_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [COORD_BITS-1:0] seed_x;
   logic [COORD_BITS-1:0] seed_y;
   logic [COORD_BITS-1:0] base_x;
   logic [COORD_BITS-1:0] base_y;
   logic [7:0]            symbol_x;
   logic [7:0]            symbol_y;

   modport source (output valid, kind, seed_x, seed_y, base_x, base_y, symbol_x, symbol_y,
                   input ready);
   modport sink (input valid, kind, seed_x, seed_y, base_x, base_y, symbol_x, symbol_y,
                 output ready);
endinterface

interface usx_rsp_if #(parameter int COORD_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COORD_BITS-1:0] frag_length;
   logic [30:0]           best_total;
   logic [30:0]           identity_count;
   logic [6:0]            similarity_pct;
   logic                  accepted;

   modport source (output valid, start_x, start_y, end_x, end_y, frag_length, best_total,
                   identity_count, similarity_pct, accepted,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, frag_length, best_total,
                 identity_count, similarity_pct, accepted,
                 output ready);
endinterface

interface usx_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/ungapped_seed_extension_core.sv
// ----------------------------------------------------------------------------
// ungapped_seed_extension_core
// Extends a seed hit along its diagonal without gaps and reports the best
// fragment. Seed, forward pair and backward pair transactions are accepted
// back to back while the core is idle. A finish transaction holds the request
// channel off until the result register is loaded: the calc state forms the
// fragment coordinates and length, eight steps of a restoring divider produce
// the similarity percent, and the done state loads the result register. The
// load waits while the previous result is still held, which stretches the
// hold-off. Configuration writes are accepted in every cycle outside reset.
// ----------------------------------------------------------------------------
module ungapped_seed_extension_core #(
   parameter int COORD_BITS = 40
) (
   input logic      clock,
   input logic      reset,
   usx_req_if.sink  req_bus,
   usx_rsp_if.source rsp_bus,
   usx_csr_if.sink  csr_bus
);
   import usx_pkg::*;

   usx_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign csr_bus.ready = !reset;

   usx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   usx_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_kind           (req_bus.kind),
      .req_seed_x         (req_bus.seed_x),
      .req_seed_y         (req_bus.seed_y),
      .req_base_x         (req_bus.base_x),
      .req_base_y         (req_bus.base_y),
      .req_symbol_x       (req_bus.symbol_x),
      .req_symbol_y       (req_bus.symbol_y),
      .csr_write          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_start_x        (rsp_bus.start_x),
      .rsp_start_y        (rsp_bus.start_y),
      .rsp_end_x          (rsp_bus.end_x),
      .rsp_end_y          (rsp_bus.end_y),
      .rsp_frag_length    (rsp_bus.frag_length),
      .rsp_best_total     (rsp_bus.best_total),
      .rsp_identity_count (rsp_bus.identity_count),
      .rsp_similarity_pct (rsp_bus.similarity_pct),
      .rsp_accepted       (rsp_bus.accepted)
   );

endmodule

### src/usx_ctrl.sv
// ----------------------------------------------------------------------------
// usx_ctrl
// Controller: item dispatch, divider sequencing and result register valid.
// ----------------------------------------------------------------------------
module usx_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [usx_pkg::KIND_W-1:0] req_kind,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output usx_pkg::usx_cmd_type     cmd
);
   import usx_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             req_acc;

   assign req_ready = !reset && (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_kind == KIND_FINISH) begin
                  state_in = S_CALC;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // finish transaction starts the result computation
   a_finish_calc: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_kind == KIND_FINISH) |=> (state_ff == S_CALC))
      else $error("finish transaction did not start computation");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CNT_LAST) |=> (state_ff == S_DONE))
      else $error("divider ran past its step count");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> out_valid_ff)
      else $error("loaded result not presented");

endmodule

### src/usx_dp.sv
// ----------------------------------------------------------------------------
// usx_dp
// Datapath: walk scoring, best fragment tracking, restoring divider and
// result register.
// ----------------------------------------------------------------------------
module usx_dp #(
   parameter int COORD_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  usx_pkg::usx_cmd_type          cmd,
   input  logic [usx_pkg::KIND_W-1:0]    req_kind,
   input  logic [COORD_BITS-1:0]         req_seed_x,
   input  logic [COORD_BITS-1:0]         req_seed_y,
   input  logic [COORD_BITS-1:0]         req_base_x,
   input  logic [COORD_BITS-1:0]         req_base_y,
   input  logic [usx_pkg::SYM_W-1:0]     req_symbol_x,
   input  logic [usx_pkg::SYM_W-1:0]     req_symbol_y,
   input  logic                          csr_write,
   input  logic [usx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [usx_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [COORD_BITS-1:0]         rsp_start_x,
   output logic [COORD_BITS-1:0]         rsp_start_y,
   output logic [COORD_BITS-1:0]         rsp_end_x,
   output logic [COORD_BITS-1:0]         rsp_end_y,
   output logic [COORD_BITS-1:0]         rsp_frag_length,
   output logic [usx_pkg::SCORE_W-1:0]   rsp_best_total,
   output logic [usx_pkg::SCORE_W-1:0]   rsp_identity_count,
   output logic [usx_pkg::PCT_W-1:0]     rsp_similarity_pct,
   output logic                          rsp_accepted
);
   import usx_pkg::*;

   localparam int DIV_W = (COORD_BITS + DEN_SHIFT + QUO_W - 1 > NUM_W) ?
                          COORD_BITS + DEN_SHIFT + QUO_W - 1 : NUM_W;
   localparam int CMP_W = (COORD_BITS > MINL_W) ? COORD_BITS : MINL_W;
   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   // configuration
   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [MINL_W-1:0] minl_ff, minl_in;
   logic [PCT_W-1:0]  thr_ff, thr_in;

   // walk state
   logic signed [RUN_W-1:0] run_score_ff, run_score_in;
   logic [SCORE_W-1:0]      peak_score_ff, peak_score_in;
   logic [SCORE_W-1:0]      run_idents_ff, run_idents_in;
   logic [SCORE_W-1:0]      peak_idents_ff, peak_idents_in;
   logic [COORD_BITS-1:0]   walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [COORD_BITS-1:0]   best_end_x_ff, best_end_x_in, best_end_y_ff, best_end_y_in;
   logic [COORD_BITS-1:0]   best_start_x_ff, best_start_x_in;
   logic [COORD_BITS-1:0]   best_start_y_ff, best_start_y_in;
   logic [COORD_BITS-1:0]   held_base_x_ff, held_base_x_in, held_base_y_ff, held_base_y_in;
   logic                    halted_ff, halted_in, bwd_ff, bwd_in;

   // result computation
   logic [COORD_BITS-1:0] w_stx_ff, w_stx_in, w_sty_ff, w_sty_in;
   logic [COORD_BITS-1:0] w_enx_ff, w_enx_in, w_eny_ff, w_eny_in;
   logic [COORD_BITS-1:0] w_len_ff, w_len_in;
   logic [SCORE_W-1:0]    w_score_ff, w_score_in, w_idents_ff, w_idents_in;
   logic [DIV_W-1:0]      rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;

   // result register
   logic [COORD_BITS-1:0] o_stx_ff, o_stx_in, o_sty_ff, o_sty_in;
   logic [COORD_BITS-1:0] o_enx_ff, o_enx_in, o_eny_ff, o_eny_in;
   logic [COORD_BITS-1:0] o_len_ff, o_len_in;
   logic [SCORE_W-1:0]    o_score_ff, o_score_in, o_idents_ff, o_idents_in;
   logic [PCT_W-1:0]      o_pct_ff, o_pct_in;
   logic                  o_acc_ff, o_acc_in;

   // configuration writes
   always_comb begin
      wlen_in = wlen_ff;
      minl_in = minl_ff;
      thr_in  = thr_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WORD_LENGTH: wlen_in = csr_data[WLEN_W-1:0];
            REG_MIN_LENGTH:  minl_in = csr_data[MINL_W-1:0];
            REG_SIM_THRESH:  thr_in  = csr_data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // walk update
   always_comb begin
      logic signed [RUN_W-1:0] eff_rs;
      logic signed [RUN_W-1:0] new_rs;
      logic signed [SUM_W-1:0] sum;
      logic [SCORE_W-1:0]      eff_ri;
      logic [SCORE_W-1:0]      new_ri;
      logic [COORD_BITS-1:0]   eff_wx;
      logic [COORD_BITS-1:0]   eff_wy;
      logic                    eff_halt;
      logic                    take;
      logic                    backward;

      run_score_in    = run_score_ff;
      peak_score_in   = peak_score_ff;
      run_idents_in   = run_idents_ff;
      peak_idents_in  = peak_idents_ff;
      walk_x_in       = walk_x_ff;
      walk_y_in       = walk_y_ff;
      best_end_x_in   = best_end_x_ff;
      best_end_y_in   = best_end_y_ff;
      best_start_x_in = best_start_x_ff;
      best_start_y_in = best_start_y_ff;
      held_base_x_in  = held_base_x_ff;
      held_base_y_in  = held_base_y_ff;
      halted_in       = halted_ff;
      bwd_in          = bwd_ff;

      eff_rs   = run_score_ff;
      eff_ri   = run_idents_ff;
      eff_wx   = walk_x_ff;
      eff_wy   = walk_y_ff;
      eff_halt = halted_ff;
      take     = 1'b0;
      backward = 1'b0;
      new_rs   = run_score_ff;
      new_ri   = run_idents_ff;
      sum      = '0;

      if (cmd.step) begin
         unique case (req_kind)
            KIND_SEED: begin
               held_base_x_in  = req_base_x;
               held_base_y_in  = req_base_y;
               walk_x_in       = req_seed_x + COORD_BITS'(wlen_ff);
               walk_y_in       = req_seed_y + COORD_BITS'(wlen_ff);
               best_end_x_in   = req_seed_x + COORD_BITS'(wlen_ff);
               best_end_y_in   = req_seed_y + COORD_BITS'(wlen_ff);
               best_start_x_in = req_seed_x;
               best_start_y_in = req_seed_y;
               run_score_in    = $signed(RUN_W'({wlen_ff, 2'b00}));
               peak_score_in   = SCORE_W'({wlen_ff, 2'b00});
               run_idents_in   = SCORE_W'(wlen_ff);
               peak_idents_in  = SCORE_W'(wlen_ff);
               halted_in       = 1'b0;
               bwd_in          = 1'b0;
            end
            KIND_FWD: begin
               take = !bwd_ff && !halted_ff;
            end
            KIND_BWD: begin
               backward = 1'b1;
               bwd_in   = 1'b1;
               // first backward pair restarts from the peak at the seed start
               if (!bwd_ff) begin
                  eff_rs   = $signed({1'b0, peak_score_ff});
                  eff_ri   = peak_idents_ff;
                  eff_wx   = best_start_x_ff - ONE;
                  eff_wy   = best_start_y_ff - ONE;
                  eff_halt = 1'b0;
               end
               run_score_in  = eff_rs;
               run_idents_in = eff_ri;
               walk_x_in     = eff_wx;
               walk_y_in     = eff_wy;
               halted_in     = eff_halt;
               take          = !eff_halt;
            end
            KIND_FINISH: ;
            default: ;
         endcase
      end

      if (take) begin
         if (req_symbol_x == SEP_SYMBOL || req_symbol_y == SEP_SYMBOL) begin
            halted_in = 1'b1;
         end else begin
            new_rs = eff_rs;
            new_ri = eff_ri;
            if (req_symbol_x == UNKNOWN_SYMBOL || req_symbol_y == UNKNOWN_SYMBOL) begin
               new_rs = eff_rs - $signed(UNK_POINT);
            end else if (req_symbol_x == req_symbol_y) begin
               sum    = SUM_W'(eff_rs) + SUM_W'(PAIR_POINT);
               new_rs = (sum > $signed({2'b00, SCORE_MAX})) ?
                        $signed({1'b0, SCORE_MAX}) : sum[RUN_W-1:0];
               new_ri = (eff_ri == SCORE_MAX) ? SCORE_MAX : eff_ri + 1'b1;
               if (new_rs > $signed({1'b0, peak_score_ff})) begin
                  peak_score_in  = new_rs[SCORE_W-1:0];
                  peak_idents_in = new_ri;
                  if (backward) begin
                     best_start_x_in = eff_wx;
                     best_start_y_in = eff_wy;
                  end else begin
                     best_end_x_in = eff_wx;
                     best_end_y_in = eff_wy;
                  end
               end
            end else begin
               new_rs = eff_rs - $signed(PAIR_POINT);
            end
            run_score_in  = new_rs;
            run_idents_in = new_ri;
            if (backward) begin
               walk_x_in = eff_wx - ONE;
               walk_y_in = eff_wy - ONE;
            end else begin
               walk_x_in = eff_wx + ONE;
               walk_y_in = eff_wy + ONE;
            end
            if (new_rs < 0) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // fragment figures and similarity division
   always_comb begin
      logic [COORD_BITS-1:0] len;
      logic [CMP_W-1:0]      len_cmp;
      logic [CMP_W-1:0]      minl_cmp;
      logic                  sim_ok;

      w_stx_in    = w_stx_ff;
      w_sty_in    = w_sty_ff;
      w_enx_in    = w_enx_ff;
      w_eny_in    = w_eny_ff;
      w_len_in    = w_len_ff;
      w_score_in  = w_score_ff;
      w_idents_in = w_idents_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      o_stx_in    = o_stx_ff;
      o_sty_in    = o_sty_ff;
      o_enx_in    = o_enx_ff;
      o_eny_in    = o_eny_ff;
      o_len_in    = o_len_ff;
      o_score_in  = o_score_ff;
      o_idents_in = o_idents_ff;
      o_pct_in    = o_pct_ff;
      o_acc_in    = o_acc_ff;

      len      = best_end_x_ff - best_start_x_ff + ONE;
      len_cmp  = CMP_W'(w_len_ff);
      minl_cmp = CMP_W'(minl_ff);
      sim_ok   = (quo_ff > QUO_W'(thr_ff)) ||
                 ((quo_ff == QUO_W'(thr_ff)) && (rem_ff != '0));

      if (cmd.calc) begin
         w_stx_in    = best_start_x_ff - held_base_x_ff;
         w_sty_in    = best_start_y_ff - held_base_y_ff;
         w_enx_in    = best_end_x_ff - held_base_x_ff;
         w_eny_in    = best_end_y_ff - held_base_y_ff;
         w_len_in    = len;
         w_score_in  = peak_score_ff;
         w_idents_in = peak_idents_ff;
         rem_in      = DIV_W'(NUM_W'(peak_score_ff) * SCALE);
         dvs_in      = DIV_W'(len) << (DEN_SHIFT + QUO_W - 1);
         quo_in      = '0;
      end

      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
      end

      if (cmd.load) begin
         o_stx_in    = w_stx_ff;
         o_sty_in    = w_sty_ff;
         o_enx_in    = w_enx_ff;
         o_eny_in    = w_eny_ff;
         o_len_in    = w_len_ff;
         o_score_in  = w_score_ff;
         o_idents_in = w_idents_ff;
         if (w_len_ff == '0) begin
            o_pct_in = '0;
            o_acc_in = 1'b0;
         end else begin
            o_pct_in = (quo_ff > QUO_W'(PCT_MAX)) ? PCT_MAX : quo_ff[PCT_W-1:0];
            o_acc_in = (len_cmp > minl_cmp) && sim_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff         <= WLEN_RESET;
         minl_ff         <= MINL_RESET;
         thr_ff          <= THRESH_RESET;
         run_score_ff    <= '0;
         peak_score_ff   <= '0;
         run_idents_ff   <= '0;
         peak_idents_ff  <= '0;
         walk_x_ff       <= '0;
         walk_y_ff       <= '0;
         best_end_x_ff   <= '0;
         best_end_y_ff   <= '0;
         best_start_x_ff <= '0;
         best_start_y_ff <= '0;
         held_base_x_ff  <= '0;
         held_base_y_ff  <= '0;
         halted_ff       <= 1'b0;
         bwd_ff          <= 1'b0;
      end else begin
         wlen_ff         <= wlen_in;
         minl_ff         <= minl_in;
         thr_ff          <= thr_in;
         run_score_ff    <= run_score_in;
         peak_score_ff   <= peak_score_in;
         run_idents_ff   <= run_idents_in;
         peak_idents_ff  <= peak_idents_in;
         walk_x_ff       <= walk_x_in;
         walk_y_ff       <= walk_y_in;
         best_end_x_ff   <= best_end_x_in;
         best_end_y_ff   <= best_end_y_in;
         best_start_x_ff <= best_start_x_in;
         best_start_y_ff <= best_start_y_in;
         held_base_x_ff  <= held_base_x_in;
         held_base_y_ff  <= held_base_y_in;
         halted_ff       <= halted_in;
         bwd_ff          <= bwd_in;
      end
   end

   always_ff @(posedge clock) begin
      w_stx_ff    <= w_stx_in;
      w_sty_ff    <= w_sty_in;
      w_enx_ff    <= w_enx_in;
      w_eny_ff    <= w_eny_in;
      w_len_ff    <= w_len_in;
      w_score_ff  <= w_score_in;
      w_idents_ff <= w_idents_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      o_stx_ff    <= o_stx_in;
      o_sty_ff    <= o_sty_in;
      o_enx_ff    <= o_enx_in;
      o_eny_ff    <= o_eny_in;
      o_len_ff    <= o_len_in;
      o_score_ff  <= o_score_in;
      o_idents_ff <= o_idents_in;
      o_pct_ff    <= o_pct_in;
      o_acc_ff    <= o_acc_in;
   end

   assign rsp_start_x        = o_stx_ff;
   assign rsp_start_y        = o_sty_ff;
   assign rsp_end_x          = o_enx_ff;
   assign rsp_end_y          = o_eny_ff;
   assign rsp_frag_length    = o_len_ff;
   assign rsp_best_total     = o_score_ff;
   assign rsp_identity_count = o_idents_ff;
   assign rsp_similarity_pct = o_pct_ff;
   assign rsp_accepted       = o_acc_ff;

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (o_pct_ff <= PCT_MAX))
      else $error("similarity percent above saturation");

   a_acc_len: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && w_len_ff == '0) |=> (!o_acc_ff && o_pct_ff == '0))
      else $error("zero length fragment reported as accepted");

   // a live walk never carries a negative score
   a_live_score: assert property (@(posedge clock) disable iff (reset)
      !halted_ff |-> (run_score_ff >= 0))
      else $error("negative score on a live walk");

endmodule
